### hw/rtl/tci_pkg.sv
// ----------------------------------------------------------------------------
// tci_pkg
// Shared types and constants of the cassette tape interface.
// ----------------------------------------------------------------------------
package tci_pkg;

    // Command codes of the input item.
    localparam logic [2:0] CMD_TAPE_BIT  = 3'd0;
    localparam logic [2:0] CMD_TICK      = 3'd1;
    localparam logic [2:0] CMD_WRITE     = 3'd2;
    localparam logic [2:0] CMD_READ      = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;
    localparam logic [2:0] CMD_RESET_CNT = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_INPUT_MODE = 1'b0;
    localparam logic CFG_ENABLED    = 1'b1;

    // Flag bit positions.
    localparam int FLAG_RX = 0;
    localparam int FLAG_TX = 1;
    localparam int FLAG_HT = 2;

    // Countdown values and register patterns.
    localparam logic [3:0]  RX_RELOAD  = 4'd9;
    localparam logic [3:0]  RX_CLEAR_AT = 4'd8;
    localparam logic [3:0]  TX_RELOAD  = 4'd9;
    localparam logic [10:0] HIGH_TONE  = 11'h3ff;
    localparam logic [1:0]  START_MARK = 2'b01;

    // Controller to datapath commands.
    typedef struct packed {
        logic latch;        // capture the accepted input item
        logic do_op;        // execute a single-step command and load the result
        logic add_cycles;   // add tick cycles to the accumulator
        logic shift_step;   // one bit period elapsed: shift in a one
        logic finish_tick;  // load the result of a tick
    } tci_ctrl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic tick_active;  // latched command is a tick that runs the timer
        logic over_period;  // accumulator exceeds one bit period
        logic out_free;     // result register can take a new result
    } tci_stat_t;

endpackage

### hw/rtl/tci_in_if.sv
// ----------------------------------------------------------------------------
// tci_in_if
// Input item channel of the cassette tape interface.
// ----------------------------------------------------------------------------
interface tci_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic        tape_bit;
    logic [11:0] cycles;
    logic [7:0]  write_byte;
    logic [2:0]  clear_mask;

    modport source (output valid, output cmd, output tape_bit, output cycles,
                    output write_byte, output clear_mask, input ready);
    modport sink   (input valid, input cmd, input tape_bit, input cycles,
                    input write_byte, input clear_mask, output ready);
endinterface

### hw/rtl/tci_out_if.sv
// ----------------------------------------------------------------------------
// tci_out_if
// Result channel of the cassette tape interface.
// ----------------------------------------------------------------------------
interface tci_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic [2:0] flags;
    logic       flags_changed;

    modport source (output valid, output read_byte, output flags,
                    output flags_changed, input ready);
    modport sink   (input valid, input read_byte, input flags,
                    input flags_changed, output ready);
endinterface

### hw/rtl/tci_datapath.sv
// ----------------------------------------------------------------------------
// tci_datapath
// Shift register, countdowns, cycle accumulator, flags and result register.
// ----------------------------------------------------------------------------
module tci_datapath #(
    parameter int BIT_PERIOD = 1664
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tci_pkg::tci_ctrl_t ctrl,
    output tci_pkg::tci_stat_t stat,
    input  logic [2:0]        item_cmd,
    input  logic              item_tape_bit,
    input  logic [11:0]       item_cycles,
    input  logic [7:0]        item_write_byte,
    input  logic [2:0]        item_clear_mask,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic              cfg_data,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [7:0]        res_read_byte,
    output logic [2:0]        res_flags,
    output logic              res_flags_changed
);

    localparam logic [12:0] PERIOD = 13'(BIT_PERIOD);

    // Latched input item.
    logic [2:0]  cmd_reg;
    logic        tape_bit_reg;
    logic [11:0] cycles_reg;
    logic [7:0]  write_byte_reg;
    logic [2:0]  clear_mask_reg;

    // Configuration.
    logic input_mode_reg;
    logic enabled_reg;

    // Architectural state.
    logic [10:0] sr_reg, sr_next;
    logic [3:0]  rx_cnt_reg, rx_cnt_next;
    logic [3:0]  tx_cnt_reg, tx_cnt_next;
    logic [12:0] accum_reg, accum_next;
    logic [2:0]  flags_reg, flags_next;
    logic [2:0]  last_reg, last_next;
    logic        changed_reg, changed_next;

    // Result register.
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [2:0] out_flags_reg, out_flags_next;
    logic       out_changed_reg, out_changed_next;

    // Effect of shifting one bit into the register.
    logic        s_bit;
    logic [10:0] s_sr;
    logic [3:0]  s_rx;
    logic [3:0]  s_tx;
    logic [2:0]  s_flags;
    logic        s_changed;

    // Effect of clearing flags.
    logic [2:0] c_flags;

    // Capture the input item on a transfer.
    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            cmd_reg        <= item_cmd;
            tape_bit_reg   <= item_tape_bit;
            cycles_reg     <= item_cycles;
            write_byte_reg <= item_write_byte;
            clear_mask_reg <= item_clear_mask;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_mode_reg <= 1'b0;
            enabled_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tci_pkg::CFG_INPUT_MODE: input_mode_reg <= cfg_data;
                tci_pkg::CFG_ENABLED:    enabled_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // One bit shifted in: countdowns and flag evaluation.
    always_comb
    begin
        s_bit   = ctrl.shift_step ? 1'b1 : tape_bit_reg;
        s_sr    = {s_bit, sr_reg[10:1]};
        s_flags = flags_reg;
        s_rx    = (rx_cnt_reg != 4'd0) ? rx_cnt_reg - 4'd1 : rx_cnt_reg;
        if (s_rx == tci_pkg::RX_CLEAR_AT)
        begin
            s_flags[tci_pkg::FLAG_RX] = 1'b0;
        end
        if (s_rx == 4'd0 && s_sr[1:0] == tci_pkg::START_MARK)
        begin
            s_flags[tci_pkg::FLAG_RX] = 1'b1;
            if (input_mode_reg)
            begin
                s_rx = tci_pkg::RX_RELOAD;
            end
        end
        s_tx = (tx_cnt_reg != 4'd0) ? tx_cnt_reg - 4'd1 : tx_cnt_reg;
        if (s_tx == 4'd0)
        begin
            s_flags[tci_pkg::FLAG_TX] = 1'b1;
        end
        s_flags[tci_pkg::FLAG_HT] = (s_sr == tci_pkg::HIGH_TONE);
        s_changed = (s_flags != last_reg);
    end

    assign c_flags = flags_reg & ~clear_mask_reg;

    // Next-state selection for the commands of the controller.
    always_comb
    begin
        sr_next          = sr_reg;
        rx_cnt_next      = rx_cnt_reg;
        tx_cnt_next      = tx_cnt_reg;
        accum_next       = accum_reg;
        flags_next       = flags_reg;
        last_next        = last_reg;
        changed_next     = changed_reg;
        out_valid_next   = out_valid_reg && !res_ready;
        out_byte_next    = out_byte_reg;
        out_flags_next   = out_flags_reg;
        out_changed_next = out_changed_reg;

        if (ctrl.add_cycles)
        begin
            accum_next   = accum_reg + {1'b0, cycles_reg};
            changed_next = 1'b0;
        end

        if (ctrl.shift_step)
        begin
            accum_next   = accum_reg - PERIOD;
            sr_next      = s_sr;
            rx_cnt_next  = s_rx;
            tx_cnt_next  = s_tx;
            flags_next   = s_flags;
            last_next    = s_flags;
            changed_next = changed_reg | s_changed;
        end

        if (ctrl.finish_tick)
        begin
            out_valid_next   = 1'b1;
            out_byte_next    = 8'd0;
            out_flags_next   = flags_reg;
            out_changed_next = changed_reg;
        end

        if (ctrl.do_op)
        begin
            out_valid_next   = 1'b1;
            out_byte_next    = 8'd0;
            out_changed_next = 1'b0;
            case (cmd_reg)
                tci_pkg::CMD_TAPE_BIT:
                begin
                    sr_next          = s_sr;
                    rx_cnt_next      = s_rx;
                    tx_cnt_next      = s_tx;
                    flags_next       = s_flags;
                    last_next        = s_flags;
                    out_changed_next = s_changed;
                end
                tci_pkg::CMD_WRITE:
                begin
                    sr_next     = {1'b0, write_byte_reg, 2'b01};
                    tx_cnt_next = tci_pkg::TX_RELOAD;
                end
                tci_pkg::CMD_READ:
                begin
                    out_byte_next = sr_reg[9:2];
                end
                tci_pkg::CMD_CLEAR:
                begin
                    flags_next       = c_flags;
                    last_next        = c_flags;
                    out_changed_next = (c_flags != last_reg);
                end
                tci_pkg::CMD_RESET_CNT:
                begin
                    accum_next  = 13'd0;
                    tx_cnt_next = 4'd0;
                end
                default:
                begin
                end
            endcase
            out_flags_next = flags_next;
        end
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg          <= 11'd0;
            rx_cnt_reg      <= 4'd0;
            tx_cnt_reg      <= 4'd0;
            accum_reg       <= 13'd0;
            flags_reg       <= 3'd0;
            last_reg        <= 3'd0;
            changed_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            sr_reg          <= sr_next;
            rx_cnt_reg      <= rx_cnt_next;
            tx_cnt_reg      <= tx_cnt_next;
            accum_reg       <= accum_next;
            flags_reg       <= flags_next;
            last_reg        <= last_next;
            changed_reg     <= changed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_byte_reg    <= out_byte_next;
        out_flags_reg   <= out_flags_next;
        out_changed_reg <= out_changed_next;
    end

    // Status to the controller.
    always_comb
    begin
        stat.tick_active = (cmd_reg == tci_pkg::CMD_TICK) && enabled_reg && !input_mode_reg;
        stat.over_period = (accum_reg > PERIOD);
        stat.out_free    = !out_valid_reg || res_ready;
    end

    assign res_valid         = out_valid_reg;
    assign res_read_byte     = out_byte_reg;
    assign res_flags         = out_flags_reg;
    assign res_flags_changed = out_changed_reg;

    // A result is only loaded when the result register is free.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.do_op || ctrl.finish_tick) |-> stat.out_free)
        else $error("result loaded while the result register is occupied");

    // A tick finishes only after all full bit periods are consumed.
    a_tick_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish_tick |-> !stat.over_period)
        else $error("tick finished with a bit period pending");

    // The receive countdown never exceeds its reload value.
    a_rx_range: assert property (@(posedge clk) disable iff (!rst_n)
        rx_cnt_reg <= tci_pkg::RX_RELOAD)
        else $error("receive countdown out of range");

    // A data write arms the transmit countdown.
    a_write_arms_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.do_op && cmd_reg == tci_pkg::CMD_WRITE) |=> tx_cnt_reg == tci_pkg::TX_RELOAD)
        else $error("transmit countdown not armed by a data write");

endmodule

### hw/rtl/tci_ctrl.sv
// ----------------------------------------------------------------------------
// tci_ctrl
// Sequencer of the cassette tape interface: takes an item, executes it and
// steps the bit-period loop of a tick.
// ----------------------------------------------------------------------------
module tci_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  tci_pkg::tci_stat_t stat,
    output tci_pkg::tci_ctrl_t ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_SHIFT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    ctrl.latch = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.tick_active)
                begin
                    ctrl.add_cycles = 1'b1;
                    state_next      = ST_SHIFT;
                end
                else if (stat.out_free)
                begin
                    ctrl.do_op = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (stat.over_period)
                begin
                    ctrl.shift_step = 1'b1;
                end
                else if (stat.out_free)
                begin
                    ctrl.finish_tick = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The item is taken only in idle, and never while a tick is stepping.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.latch |=> state_reg == ST_EXEC)
        else $error("accepted item not executed next");

    // Only one datapath command at a time.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.latch, ctrl.do_op, ctrl.add_cycles, ctrl.shift_step,
                  ctrl.finish_tick}))
        else $error("overlapping datapath commands");

    // A bit-period step only happens while the loop is running.
    a_step_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift_step |=> state_reg == ST_SHIFT)
        else $error("bit-period step left the loop");

endmodule

### hw/rtl/tape_cassette_interface_top.sv
// ----------------------------------------------------------------------------
// tape_cassette_interface_top
// Cassette tape interface: shift register, countdowns and interrupt flags.
// ----------------------------------------------------------------------------
// An item is taken in the idle state and executed in the execute state, which
// waits while the result register is occupied. A tick in output mode with the
// interface enabled adds its cycles to the accumulator and then shifts one bit
// for each bit period it completes, at one bit per cycle through the
// single flag-evaluation unit. The result register lets the next item be
// taken while a result waits; execution holds only when a new result would
// overwrite one not yet transferred. Configuration is written through a
// plain write port at any idle time.
module tape_cassette_interface_top #(
    parameter int BIT_PERIOD = 1664
) (
    input  logic     clk,
    input  logic     rst_n,
    tci_in_if.sink   item,
    tci_out_if.source result,
    input  logic     cfg_wr_en,
    input  logic     cfg_index,
    input  logic     cfg_data
);

    tci_pkg::tci_ctrl_t ctrl;
    tci_pkg::tci_stat_t stat;

    // Sequencer.
    tci_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .stat       (stat),
        .ctrl       (ctrl)
    );

    // Datapath.
    tci_datapath #(
        .BIT_PERIOD (BIT_PERIOD)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .stat              (stat),
        .item_cmd          (item.cmd),
        .item_tape_bit     (item.tape_bit),
        .item_cycles       (item.cycles),
        .item_write_byte   (item.write_byte),
        .item_clear_mask   (item.clear_mask),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .res_valid         (result.valid),
        .res_ready         (result.ready),
        .res_read_byte     (result.read_byte),
        .res_flags         (result.flags),
        .res_flags_changed (result.flags_changed)
    );

endmodule
